### hw/rtl/pcpg_pkg.sv
`default_nettype none
package pcpg_pkg;

  // field and datapath widths
  localparam int CENTER_W = 11;
  localparam int RADIUS_W = 10;
  localparam int X_W      = 11;
  localparam int Y_W      = 11;
  localparam int FIELD_W  = 12;
  localparam int RAD_W    = 20;
  localparam int ROOT_W   = RAD_W + 1;
  localparam int BIT_W    = RAD_W - 1;
  localparam int ROOT_ITERS = RAD_W / 2;
  localparam int CNT_W    = 4;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

  // square root unit request and response
  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic           done;
    logic [Y_W-1:0] root;
  } sqrt_rsp_t;

endpackage
`default_nettype wire

### hw/rtl/pcpg_sqrt.sv
`default_nettype none
module pcpg_sqrt (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pcpg_pkg::sqrt_req_t  req,
  output pcpg_pkg::sqrt_rsp_t       rsp
);
  import pcpg_pkg::*;

  logic              active;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [BIT_W-1:0]  bitv;
  logic [ROOT_W-1:0] trial;
  logic              take;
  logic              last_iter;
  logic              done_r;
  logic [Y_W-1:0]    root_r;

  // one shift-subtract step per cycle
  assign trial     = root + ROOT_W'(bitv);
  assign take      = ROOT_W'(rem) >= trial;
  assign last_iter = (cnt == CNT_W'(ROOT_ITERS));

  assign rsp = '{done: done_r, root: root_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= active && last_iter;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        if (last_iter) begin
          active <= 1'b0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  // datapath: start loads, iterations refine, last cycle rounds
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.radicand;
      root <= '0;
      bitv <= {1'b1, {(BIT_W-1){1'b0}}};
    end else if (active) begin
      if (last_iter) begin
        root_r <= Y_W'(root) + Y_W'(ROOT_W'(rem) > root);
      end else begin
        if (take) begin
          rem  <= RAD_W'(ROOT_W'(rem) - trial);
          root <= (root >> 1) + ROOT_W'(bitv);
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
    end
  end

  // a result only follows a running root
  a_done_after_active: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(active))
    else $error("root done without a running iteration");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    req.start |=> (active && cnt == '0))
    else $error("root unit did not start");

endmodule
`default_nettype wire

### hw/rtl/pcpg_point.sv
`default_nettype none
module pcpg_point #(
  parameter int COORD_WIDTH = 12
) (
  input  wire logic signed [pcpg_pkg::CENTER_W-1:0] center_x,
  input  wire logic signed [pcpg_pkg::CENTER_W-1:0] center_y,
  input  wire logic        [pcpg_pkg::X_W-1:0]      a,
  input  wire logic        [pcpg_pkg::Y_W-1:0]      b,
  input  wire logic        [2:0]                    idx,
  output logic             [pcpg_pkg::FIELD_W-1:0]  point_x,
  output logic             [pcpg_pkg::FIELD_W-1:0]  point_y
);
  import pcpg_pkg::*;

  localparam int SUM_W = 17;
  localparam int SH    = SUM_W - COORD_WIDTH;

  logic        [X_W-1:0]   dx;
  logic        [X_W-1:0]   dy;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] shl_x;
  logic signed [SUM_W-1:0] shl_y;
  logic signed [SUM_W-1:0] wrap_x;
  logic signed [SUM_W-1:0] wrap_y;

  // octant mapping: bit 2 swaps the offsets, bits 0 and 1 negate x and y
  assign dx = idx[2] ? X_W'(b) : a;
  assign dy = idx[2] ? a : X_W'(b);

  always_comb begin
    if (idx[0]) begin
      sum_x = SUM_W'(center_x) - $signed(SUM_W'(dx));
    end else begin
      sum_x = SUM_W'(center_x) + $signed(SUM_W'(dx));
    end
    if (idx[1]) begin
      sum_y = SUM_W'(center_y) - $signed(SUM_W'(dy));
    end else begin
      sum_y = SUM_W'(center_y) + $signed(SUM_W'(dy));
    end
  end

  // wrap to the coordinate width, then sign-extend back
  assign shl_x  = sum_x <<< SH;
  assign shl_y  = sum_y <<< SH;
  assign wrap_x = shl_x >>> SH;
  assign wrap_y = shl_y >>> SH;

  assign point_x = wrap_x[FIELD_W-1:0];
  assign point_y = wrap_y[FIELD_W-1:0];

endmodule
`default_nettype wire

### hw/rtl/polynomial_circle_point_generator.sv
// Each step item: squaring and subtract (S_MUL_R, S_MUL_X, S_SUB), iterations in the
// shift-subtract root unit, taking the root, then eight points at one per cycle
// while out_ready is high.
// A step while no circle is active is taken and gives no point.
// Synchronous active-high reset clears the configuration registers to 0, octant x
// to 0 and marks no circle active.
`default_nettype none
module polynomial_circle_point_generator #(
  parameter int COORD_WIDTH = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pcpg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pcpg_pkg::CENTER_W-1:0]        cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 start_new,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [pcpg_pkg::FIELD_W-1:0]         point_x,
  output logic      [pcpg_pkg::FIELD_W-1:0]         point_y,
  output logic                                      last_of_step,
  output logic                                      circle_done
);
  import pcpg_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL_R = 6'b000010,
    S_MUL_X = 6'b000100,
    S_SUB   = 6'b001000,
    S_ROOT  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                     state;
  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_y;
  logic        [RADIUS_W-1:0] circle_radius;
  logic        [X_W-1:0]      octant_x;
  logic                       finished;
  logic        [RAD_W-1:0]    rr;
  logic        [RAD_W:0]      xx;
  logic        [Y_W-1:0]      y;
  logic                       done_q;
  logic        [2:0]          k;
  logic        [X_W-1:0]      mul_a;
  logic        [2*X_W-1:0]    prod;
  logic        [RAD_W-1:0]    radicand;
  logic                       in_take;
  logic                       out_take;
  sqrt_req_t                  sq_req;
  sqrt_rsp_t                  sq_rsp;

  // registers take writes only between steps
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE);
  assign in_take   = in_valid && in_ready;
  assign out_valid = (state == S_EMIT);
  assign out_take  = out_valid && out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      circle_radius <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x      <= cfg_data;
        CFG_CENTER_Y: center_y      <= cfg_data;
        CFG_RADIUS:   circle_radius <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // shared squarer: r*r first, then x*x
  assign mul_a = (state == S_MUL_R) ? X_W'(circle_radius) : octant_x;
  assign prod  = mul_a * mul_a;

  // radicand clamps to zero once x passes the radius
  assign radicand = (octant_x > X_W'(circle_radius)) ? '0 : RAD_W'(rr - xx[RAD_W-1:0]);

  assign sq_req.start    = (state == S_SUB);
  assign sq_req.radicand = radicand;

  pcpg_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      octant_x <= '0;
      finished <= 1'b1;
      k        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (start_new) begin
              octant_x <= '0;
              finished <= 1'b0;
              state    <= S_MUL_R;
            end else if (!finished) begin
              state <= S_MUL_R;
            end
          end
        end
        S_MUL_R: state <= S_MUL_X;
        S_MUL_X: state <= S_SUB;
        S_SUB:   state <= S_ROOT;
        S_ROOT: begin
          if (sq_rsp.done) begin
            k     <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_take) begin
            k <= k + 3'd1;
            if (k == 3'd7) begin
              octant_x <= octant_x + X_W'(1);
              if (done_q) begin
                finished <= 1'b1;
              end
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_MUL_R) begin
      rr <= prod[RAD_W-1:0];
    end
    if (state == S_MUL_X) begin
      xx <= prod[RAD_W:0];
    end
    if (state == S_ROOT && sq_rsp.done) begin
      y      <= sq_rsp.root;
      done_q <= (sq_rsp.root <= Y_W'(octant_x));
    end
  end

  pcpg_point #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_point (
    .center_x (center_x),
    .center_y (center_y),
    .a        (octant_x),
    .b        (y),
    .idx      (k),
    .point_x  (point_x),
    .point_y  (point_y)
  );

  assign last_of_step = (k == 3'd7);
  assign circle_done  = done_q;

  // input and output sides never open together
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while points pending");

  a_root_in_root_state: assert property (@(posedge clk) disable iff (rst)
    sq_rsp.done |-> (state == S_ROOT))
    else $error("root result outside root wait");

  a_step_ends: assert property (@(posedge clk) disable iff (rst)
    (out_take && last_of_step) |=> in_ready)
    else $error("sequencer did not return after eighth point");

  a_circle_ends: assert property (@(posedge clk) disable iff (rst)
    (out_take && last_of_step && circle_done) |=> finished)
    else $error("circle not marked finished");

endmodule
`default_nettype wire
